/* rtl/cwcs_pkg.sv */
// Types and character constants shared by the CSS whitespace and comment stripper.
package cwcs_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } cwcs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_block;
  } cwcs_out_t;

  typedef enum logic [1:0] {
    PhaseOutside   = 2'd0,
    PhaseInside    = 2'd1,
    PhaseAfterStar = 2'd2
  } cwcs_phase_e;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChVt     = 8'h0b;
  localparam logic [7:0] ChFf     = 8'h0c;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChLt     = 8'h3c;
  localparam logic [7:0] ChGt     = 8'h3e;
  localparam logic [7:0] ChLBrack = 8'h5b;
  localparam logic [7:0] ChRBrack = 8'h5d;
  localparam logic [7:0] ChEq     = 8'h3d;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChAt     = 8'h40;

endpackage

/* rtl/css_whitespace_comment_stripper_core.sv */
// Top level of the CSS whitespace and comment stripper.
// Accepts one byte per cycle on the input channel; each accepted byte is decided in the
// same cycle and yields zero, one or two result transactions, written into a four-entry
// result queue that drains one transaction per cycle while out_stall_i is low. Input
// stalls only while the queue holds more than two results, so the block sustains one
// byte per cycle as long as the text yields at most one result per byte on average; a
// byte that releases both a held slash or space and itself yields two results. The
// final byte of a block always yields at least one result (a bare end marker when
// nothing is emitted) and returns all scanning state to its reset value. prelude_mode
// may be written at any time and applies from the next accepted byte.
module css_whitespace_comment_stripper_core
  import cwcs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  cwcs_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output cwcs_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  function automatic logic is_ws(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChVt) ||
           (c == ChFf) || (c == ChCr);
  endfunction

  function automatic logic is_delim(logic [7:0] c, logic with_lparen);
    logic r;
    case (c)
      ChRParen, ChLt, ChGt, ChLBrack, ChRBrack,
      ChEq, ChComma, ChColon, ChSemi, ChAt: r = 1'b1;
      ChLParen: r = with_lparen;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

  logic        prelude_mode_q;
  cwcs_phase_e phase_q, phase_d;
  logic        slash_held_q, slash_held_d;
  logic        space_held_q, space_held_d;
  logic [7:0]  held_char_q, held_char_d;
  logic        space_supp_q, space_supp_d;

  cwcs_out_t   queue_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  logic        in_accept, out_accept;
  cwcs_out_t   res0, res1;
  logic [1:0]  n_res;

  assign in_stall_o  = (count_q > CntW'(QDepth - 2));
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign out_accept  = out_valid_o & ~out_stall_i;
  assign out_data_o  = queue_q[rd_ptr_q];

  always_comb begin
    logic [7:0] b;
    logic       last;
    logic       fresh;
    b            = in_data_i.in_byte;
    last         = in_data_i.is_last;
    fresh        = 1'b1;
    phase_d      = phase_q;
    slash_held_d = slash_held_q;
    space_held_d = space_held_q;
    held_char_d  = held_char_q;
    space_supp_d = space_supp_q;
    res0         = '0;
    res1         = '0;
    n_res        = 2'd0;

    if (phase_q != PhaseOutside) begin
      fresh = 1'b0;
      if (phase_q == PhaseAfterStar && b == ChSlash) begin
        phase_d = PhaseOutside;
      end else if (b == ChStar) begin
        phase_d = PhaseAfterStar;
      end else begin
        phase_d = PhaseInside;
      end
    end else if (slash_held_q) begin
      slash_held_d = 1'b0;
      if (b == ChStar) begin
        phase_d = PhaseInside;
        fresh   = 1'b0;
      end else begin
        res0         = '{out_byte: ChSlash, byte_valid: 1'b1, end_of_block: 1'b0};
        n_res        = 2'd1;
        space_supp_d = 1'b0;
      end
    end else if (space_held_q) begin
      space_held_d = 1'b0;
      if (!(is_ws(b) || is_delim(b, ~prelude_mode_q)) && !space_supp_q) begin
        res0         = '{out_byte: held_char_q, byte_valid: 1'b1, end_of_block: 1'b0};
        n_res        = 2'd1;
        space_supp_d = 1'b1;
      end
      held_char_d = '0;
    end

    if (fresh) begin
      if (b == ChSlash && !last) begin
        slash_held_d = 1'b1;
      end else if (is_ws(b)) begin
        if (!last) begin
          space_held_d = 1'b1;
          held_char_d  = b;
        end
      end else begin
        if (n_res == 2'd0) begin
          res0 = '{out_byte: b, byte_valid: 1'b1, end_of_block: 1'b0};
        end else begin
          res1 = '{out_byte: b, byte_valid: 1'b1, end_of_block: 1'b0};
        end
        n_res        = n_res + 2'd1;
        space_supp_d = is_ws(b) | is_delim(b, 1'b1);
      end
    end

    if (last) begin
      case (n_res)
        2'd0: begin
          res0  = '{out_byte: 8'd0, byte_valid: 1'b0, end_of_block: 1'b1};
          n_res = 2'd1;
        end
        2'd1:    res0.end_of_block = 1'b1;
        default: res1.end_of_block = 1'b1;
      endcase
      phase_d      = PhaseOutside;
      slash_held_d = 1'b0;
      space_held_d = 1'b0;
      held_char_d  = '0;
      space_supp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prelude_mode_q <= 1'b0;
      phase_q        <= PhaseOutside;
      slash_held_q   <= 1'b0;
      space_held_q   <= 1'b0;
      held_char_q    <= '0;
      space_supp_q   <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        prelude_mode_q <= cfg_data_i;
      end
      if (in_accept) begin
        phase_q      <= phase_d;
        slash_held_q <= slash_held_d;
        space_held_q <= space_held_d;
        held_char_q  <= held_char_d;
        space_supp_q <= space_supp_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_accept) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      end
      if (out_accept) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + (in_accept ? CntW'(n_res) : CntW'(0))
                         - (out_accept ? CntW'(1) : CntW'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      queue_q[wr_ptr_q] <= res0;
      if (n_res == 2'd2) begin
        queue_q[wr_ptr_q + PtrW'(1)] <= res1;
      end
    end
  end

endmodule

/* rtl/cwcs_checker.sv */
// Port-level checks for the CSS whitespace and comment stripper, bound to the top level.
module cwcs_checker
  import cwcs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input cwcs_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input cwcs_out_t out_data_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output transaction changed while stalled");

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |->
      out_data_o.end_of_block && (out_data_o.out_byte == 8'd0))
    else $error("empty result is not a bare end marker");

  a_idle_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("activity during reset");

endmodule

bind css_whitespace_comment_stripper_core cwcs_checker u_cwcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* dv/css_strip_checker.sv */
// Checker for the CSS stripper: predicts minified output per accepted byte and compares.
module css_strip_checker
  import cwcs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  cwcs_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  cwcs_out_t out_data_i,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  output int        mismatches_o,
  output int        pending_o
);

  localparam int PrintLimit = 30;

  logic        prelude_mode;
  cwcs_phase_e phase;
  logic        slash_held;
  logic        space_held;
  logic [7:0]  held_space;
  logic        space_supp;

  cwcs_out_t   step_q[$];
  cwcs_out_t   minified_q[$];
  int          mismatch_cnt;

  function automatic logic is_space(logic [7:0] c);
    return c inside {ChSpace, ChTab, ChLf, ChVt, ChFf, ChCr};
  endfunction

  function automatic logic is_delim(logic [7:0] c, logic with_lparen);
    case (c)
      ChRParen, ChLt, ChGt, ChLBrack, ChRBrack, ChEq, ChComma, ChColon, ChSemi, ChAt: begin
        return 1'b1;
      end
      ChLParen: begin
        return with_lparen;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic ends_token(logic [7:0] c, logic with_lparen);
    return is_space(c) || is_delim(c, with_lparen);
  endfunction

  function automatic void put_char(logic [7:0] c);
    cwcs_out_t res;
    res.out_byte     = c;
    res.byte_valid   = 1'b1;
    res.end_of_block = 1'b0;
    step_q.push_back(res);
    space_supp = ends_token(c, 1'b1);
  endfunction

  function automatic void clear_scan();
    phase      = PhaseOutside;
    slash_held = 1'b0;
    space_held = 1'b0;
    held_space = 8'h00;
    space_supp = 1'b1;
  endfunction

  task automatic minify_byte(cwcs_in_t item);
    logic       fresh;
    logic [7:0] b;
    cwcs_out_t  marker;
    b     = item.in_byte;
    fresh = 1'b1;
    step_q.delete();
    if (phase != PhaseOutside) begin
      fresh = 1'b0;
      if (phase == PhaseAfterStar && b == ChSlash) begin
        phase = PhaseOutside;
      end else if (b == ChStar) begin
        phase = PhaseAfterStar;
      end else begin
        phase = PhaseInside;
      end
    end else if (slash_held) begin
      slash_held = 1'b0;
      if (b == ChStar) begin
        phase = PhaseInside;
        fresh = 1'b0;
      end else begin
        put_char(ChSlash);
      end
    end else if (space_held) begin
      space_held = 1'b0;
      if (!ends_token(b, !prelude_mode) && !space_supp) begin
        put_char(held_space);
      end
      held_space = 8'h00;
    end
    if (fresh) begin
      if (b == ChSlash) begin
        if (item.is_last) begin
          put_char(b);
        end else begin
          slash_held = 1'b1;
        end
      end else if (is_space(b)) begin
        if (!item.is_last) begin
          space_held = 1'b1;
          held_space = b;
        end
      end else begin
        put_char(b);
      end
    end
    if (item.is_last) begin
      if (step_q.size() == 0) begin
        marker.out_byte     = 8'h00;
        marker.byte_valid   = 1'b0;
        marker.end_of_block = 1'b1;
        step_q.push_back(marker);
      end else begin
        step_q[step_q.size() - 1].end_of_block = 1'b1;
      end
      clear_scan();
    end
    foreach (step_q[i]) minified_q.push_back(step_q[i]);
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < PrintLimit) $display("MISMATCH: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic check_result(cwcs_out_t got);
    cwcs_out_t want;
    if (minified_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction byte=%02h valid=%0b eob=%0b",
                                got.out_byte, got.byte_valid, got.end_of_block));
    end else begin
      want = minified_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
      if (got.byte_valid !== want.byte_valid)
        report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                  got.byte_valid, want.byte_valid));
      if (got.end_of_block !== want.end_of_block)
        report_mismatch($sformatf("end_of_block %0b, expected %0b",
                                  got.end_of_block, want.end_of_block));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prelude_mode = 1'b0;
      clear_scan();
      minified_q.delete();
      mismatch_cnt = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) minify_byte(in_data_i);
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (cfg_we_i) prelude_mode = cfg_data_i;
      mismatches_o <= mismatch_cnt;
      pending_o    <= minified_q.size();
    end
  end

endmodule

/* dv/tb_css_whitespace_comment_stripper_core.sv */
// Testbench top for the CSS whitespace and comment stripper: stimulus, idling and verdict.
module tb_css_whitespace_comment_stripper_core;
  import cwcs_pkg::*;

  localparam int IdleLimit  = 2000;
  localparam int ItemTarget = 1300;
  localparam int PhaseItems = 200;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  cwcs_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  cwcs_out_t out_data;
  logic      cfg_we;
  logic      cfg_data;
  logic      steady;
  int        mismatches;
  int        pending;
  int        items_sent  = 0;
  int        idle_cycles = 0;

  css_whitespace_comment_stripper_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  css_strip_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
          $display("** css_whitespace_comment_stripper_core: FAILED **");
          $finish;
        end
      end
    end
  end

  // Result side: random stall before each transaction.
  initial begin
    int w;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      w = steady ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic logic [7:0] word_char();
    string chars = "abcdefghijklmnopqrstuvwxyz0123456789-#.%";
    return chars[$urandom_range(0, chars.len() - 1)];
  endfunction

  function automatic logic [7:0] ws_char();
    case ($urandom_range(0, 5))
      0: return ChSpace;
      1: return ChTab;
      2: return ChLf;
      3: return ChVt;
      4: return ChFf;
      default: return ChCr;
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, logic is_last);
    int w;
    w = steady ? 0 : $urandom_range(0, 4);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data.in_byte <= b;
    in_data.is_last <= is_last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic write_mode(logic m);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // CSS-like token soup; the cut to the target length leaves some comments open.
  task automatic random_block();
    logic [7:0] text[$];
    logic [7:0] delims[11];
    int         target;
    int         kind;
    delims = '{ChLParen, ChRParen, ChLt, ChGt, ChLBrack, ChRBrack, ChEq, ChComma, ChColon,
               ChSemi, ChAt};
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 16);
    while (text.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        repeat ($urandom_range(1, 5)) text.push_back(word_char());
      end else if (kind < 50) begin
        repeat ($urandom_range(1, 3)) text.push_back(ws_char());
      end else if (kind < 65) begin
        text.push_back(delims[$urandom_range(0, 10)]);
      end else if (kind < 80) begin
        text.push_back(ChSlash);
        text.push_back(ChStar);
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 3))
            0: text.push_back(ChStar);
            1: text.push_back(ChSlash);
            2: text.push_back(ws_char());
            default: text.push_back(word_char());
          endcase
        end
        if ($urandom_range(0, 7) != 0) begin
          text.push_back(ChStar);
          text.push_back(ChSlash);
        end
      end else if (kind < 88) begin
        text.push_back($urandom_range(0, 1) ? ChSlash : ChStar);
      end else begin
        text.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (text.size() > target) void'(text.pop_back());
    foreach (text[i]) send_byte(text[i], i == target - 1);
  endtask

  initial begin
    int phase_start;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_data = 1'b0;
    steady   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_text(" a\t/*/*/\nb /");
    send_text("/*ab");
    send_text("\n");
    write_mode(1'b1);
    send_text("@m (a)");

    for (int p = 0; items_sent < ItemTarget; p++) begin
      write_mode(p == 0 ? 1'b0 : (p == 1 ? 1'b1 : 1'($urandom_range(0, 1))));
      steady      = (p % 3 == 2);
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems && items_sent < ItemTarget) random_block();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** css_whitespace_comment_stripper_core: PASSED **");
    end else begin
      $display("** css_whitespace_comment_stripper_core: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cwcs_pkg.sv
rtl/css_whitespace_comment_stripper_core.sv
rtl/cwcs_checker.sv
dv/css_strip_checker.sv
dv/tb_css_whitespace_comment_stripper_core.sv
